// ===== hw/rtl/blob_track_association_table_top_defines.svh =====
// Assertion macros shared by the checker of the track association table.
`ifndef BLOB_TRACK_ASSOCIATION_TABLE_TOP_DEFINES_SVH
`define BLOB_TRACK_ASSOCIATION_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BTAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BTAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/btat_pkg.sv =====
// Shared types, constants and helpers of the track association table.
`default_nettype none
package btat_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = 4;
  localparam int COORD_W   = 12;
  localparam int AREA_W    = 24;
  localparam int LABEL_W   = 32;
  localparam int FRAME_W   = 32;
  localparam int SIGHT_W   = 8;
  localparam int DIST_W    = 13;
  localparam int RAD_W     = 7;
  localparam int PCT_W     = 7;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 4;
  localparam int VIS_W     = 5;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int TOL_W     = PROD_W + PCT_W;

  localparam logic [RAD_W-1:0]   RADIUS_BASE     = 7'd28;
  localparam logic [RAD_W-1:0]   RADIUS_CAP      = 7'd101;
  localparam logic [FRAME_W-1:0] RADIUS_AGE_CAP  = 32'd73;
  localparam logic [SIGHT_W-1:0] YOUNG_SIGHTINGS = 8'd5;
  localparam logic [FRAME_W-1:0] YOUNG_MAX_AGE   = 32'd5;
  localparam logic [FRAME_W-1:0] OLD_MAX_AGE     = 32'd50;
  localparam logic [SIGHT_W-1:0] SIGHT_MAX       = 8'd255;
  localparam logic [AREA_W-1:0]  AREA_MAX        = 24'hFFFFFF;
  localparam logic [PCT_W-1:0]   PCT_DIV         = 7'd100;
  localparam logic [CFG_W-1:0]   FRAME_MIN       = 13'd2;

  localparam logic [PCT_W-1:0] AREA_TOL_RST  = 7'd20;
  localparam logic [CFG_W-1:0] SHAPE_TOL_RST = 13'd100;
  localparam logic [CFG_W-1:0] FRAME_W_RST   = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_H_RST   = 13'd480;

  localparam logic [CFG_IDX_W-1:0] REG_AREA_TOL  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_TOL = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_W   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_H   = 4'd3;

  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] corner_x;
    logic [COORD_W-1:0] corner_y;
    logic [COORD_W-1:0] box_width;
    logic [COORD_W-1:0] box_height;
    logic [AREA_W-1:0]  blob_area;
  } req_t;

  typedef struct packed {
    logic               matched;
    logic [IDX_W-1:0]   slot;
    logic               dropped;
    logic [LABEL_W-1:0] object_label;
    logic [VIS_W-1:0]   visible_count;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic chk1;
    logic chk2;
    logic decide;
    logic commit;
    logic age;
    logic frame;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic out_free;
  } sts_t;

  function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/btat_in_if.sv =====
// Input word channel of the track association table.
`default_nettype none
interface btat_in_if;
  logic          valid;
  logic          ready;
  btat_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/btat_out_if.sv =====
// Result word channel of the track association table.
`default_nettype none
interface btat_out_if;
  logic          valid;
  logic          ready;
  btat_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/btat_cfg_if.sv =====
// Register write channel of the track association table.
`default_nettype none
interface btat_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [btat_pkg::CFG_IDX_W-1:0]      index;
  logic [btat_pkg::CFG_W-1:0]          data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/blob_track_association_table_top.sv =====
// Top level of the blob track association table.
// Usage:
//   req carries one word per blob (req_type 0) or per frame end (req_type 1).
//   rsp returns exactly one word for every accepted req word, in order.
//   cfg writes the four tolerance and frame size registers; it is always
//   ready. The user must write it only while no word is in flight; the block does not enforce this.
// Timing:
//   A blob is worked from acceptance to a loaded result in steps: a distance
//   scan over every table slot, the multiply steps CHK1 and CHK2 for the area
//   limit, a decide step and an update step. A frame end ages every slot in
//   turn, then advances the frame.
//   One word is worked at a time: the next is accepted only once the result
//   of the last one is loaded; the 16-slot sweep makes up most of each word's work.
//   req accepts the next word while a result still waits in the rsp register.
// Reset: rst clears the table valid and merge marks, the label counter,
//   sets the frame counter to one and loads register defaults.
// Stall: a held rsp word stays stable; the next word finishes its work and
//   then waits until the rsp register frees.
`default_nettype none
module blob_track_association_table_top (
  input  wire logic  clk,
  input  wire logic  rst,
  btat_in_if.sink    req,
  btat_out_if.source rsp,
  btat_cfg_if.sink   cfg
);

  btat_pkg::cmd_t cmd;
  btat_pkg::sts_t sts;

  assign cfg.ready = 1'b1;

  btat_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (req.valid),
    .in_frame_end (req.data.req_type),
    .in_ready     (req.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  btat_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_data  (req.data),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/btat_ctrl.sv =====
// Sequencer that steps the datapath through scan, check, update and ageing.
`default_nettype none
module btat_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           in_frame_end,
  output logic                in_ready,
  input  wire btat_pkg::sts_t sts,
  output btat_pkg::cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCAN   = 9'b000000010,
    S_CHK1   = 9'b000000100,
    S_CHK2   = 9'b000001000,
    S_DECIDE = 9'b000010000,
    S_COMMIT = 9'b000100000,
    S_AGE    = 9'b001000000,
    S_FRAME  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = in_frame_end ? S_AGE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.idx_last) state_next = S_CHK1;
      end
      S_CHK1: begin
        cmd.chk1   = 1'b1;
        state_next = S_CHK2;
      end
      S_CHK2: begin
        cmd.chk2   = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_AGE: begin
        cmd.age = 1'b1;
        if (sts.idx_last) state_next = S_FRAME;
      end
      S_FRAME: begin
        cmd.frame  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/btat_datapath.sv =====
// Track table storage, distance scan, match checks, ageing and result register.
`default_nettype none
module btat_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire btat_pkg::cmd_t                 cmd,
  output btat_pkg::sts_t                      sts,
  input  wire btat_pkg::req_t                 req_data,
  input  wire logic                           cfg_valid,
  input  wire logic [btat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [btat_pkg::CFG_W-1:0]     cfg_data,
  output logic                                rsp_valid,
  input  wire logic                           rsp_ready,
  output btat_pkg::rsp_t                      rsp_data
);

  localparam int N = btat_pkg::ENTRIES;

  logic [btat_pkg::PCT_W-1:0] area_tol;
  logic [btat_pkg::CFG_W-1:0] shape_tol;
  logic [btat_pkg::CFG_W-1:0] frame_w;
  logic [btat_pkg::CFG_W-1:0] frame_h;

  logic [N-1:0]                     e_valid;
  logic [N-1:0]                     e_merged;
  logic [btat_pkg::COORD_W-1:0]     e_cx [N];
  logic [btat_pkg::COORD_W-1:0]     e_cy [N];
  logic [btat_pkg::COORD_W-1:0]     e_kx [N];
  logic [btat_pkg::COORD_W-1:0]     e_ky [N];
  logic [btat_pkg::AREA_W-1:0]      e_area [N];
  logic [btat_pkg::COORD_W-1:0]     e_w [N];
  logic [btat_pkg::COORD_W-1:0]     e_h [N];
  logic [btat_pkg::SIGHT_W-1:0]     e_sight [N];
  logic [btat_pkg::FRAME_W-1:0]     e_last [N];
  logic [btat_pkg::LABEL_W-1:0]     e_label [N];

  logic [btat_pkg::LABEL_W-1:0] label_cnt;
  logic [btat_pkg::FRAME_W-1:0] frame_cnt;

  btat_pkg::req_t                 cur;
  logic [btat_pkg::IDX_W-1:0]     idx;
  logic [btat_pkg::IDX_W-1:0]     hit;
  logic [btat_pkg::IDX_W-1:0]     free_slot;
  logic                           hit_found;
  logic                           free_found;
  logic [btat_pkg::RAD_W-1:0]     best;
  logic [btat_pkg::DIST_W-1:0]    dshape;
  logic [btat_pkg::AREA_W-1:0]    darea;
  logic [btat_pkg::PROD_W-1:0]    prod_wh;
  logic [btat_pkg::TOL_W-1:0]     area_lim;
  logic [btat_pkg::TOL_W-1:0]     darea_x;
  logic                           pass;
  logic [btat_pkg::VIS_W-1:0]     vis;
  btat_pkg::rsp_t                 res;

  logic [btat_pkg::IDX_W-1:0]     rd;
  logic [btat_pkg::FRAME_W-1:0]   age;
  logic [btat_pkg::RAD_W-1:0]     radius;
  logic [btat_pkg::DIST_W-1:0]    span;
  logic [btat_pkg::CFG_W-1:0]     fw;
  logic [btat_pkg::CFG_W-1:0]     fh;
  logic                           seen_now;
  logic                           kill;
  logic [btat_pkg::LABEL_W-1:0]   label_new;
  logic [btat_pkg::COORD_W:0]     sum_cx;
  logic [btat_pkg::COORD_W:0]     sum_cy;
  logic [btat_pkg::COORD_W:0]     sum_w;
  logic [btat_pkg::COORD_W:0]     sum_h;
  logic [btat_pkg::AREA_W:0]      sum_area;

  assign rd = (cmd.chk1 || cmd.commit) ? hit : idx;
  assign age = frame_cnt - e_last[rd];
  assign radius = (age >= btat_pkg::RADIUS_AGE_CAP) ? btat_pkg::RADIUS_CAP
                : btat_pkg::RADIUS_BASE + age[btat_pkg::RAD_W-1:0];
  assign span = btat_pkg::DIST_W'(btat_pkg::absdiff(e_cx[rd], cur.center_x))
              + btat_pkg::DIST_W'(btat_pkg::absdiff(e_cy[rd], cur.center_y));
  assign fw = (frame_w < btat_pkg::FRAME_MIN) ? btat_pkg::FRAME_MIN : frame_w;
  assign fh = (frame_h < btat_pkg::FRAME_MIN) ? btat_pkg::FRAME_MIN : frame_h;
  assign seen_now = (e_last[rd] == frame_cnt);
  assign kill = (e_sight[rd] < btat_pkg::YOUNG_SIGHTINGS) ? (age > btat_pkg::YOUNG_MAX_AGE)
                                                          : (age > btat_pkg::OLD_MAX_AGE);
  assign label_new = label_cnt + 1'b1;
  assign sum_cx = {1'b0, e_cx[rd]} + {1'b0, cur.center_x};
  assign sum_cy = {1'b0, e_cy[rd]} + {1'b0, cur.center_y};
  assign sum_w = {1'b0, e_w[rd]} + {1'b0, cur.box_width};
  assign sum_h = {1'b0, e_h[rd]} + {1'b0, cur.box_height};
  assign sum_area = {1'b0, e_area[rd]} + {1'b0, cur.blob_area};

  assign sts.idx_last = (idx == btat_pkg::IDX_W'(N - 1));
  assign sts.out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_tol  <= btat_pkg::AREA_TOL_RST;
      shape_tol <= btat_pkg::SHAPE_TOL_RST;
      frame_w   <= btat_pkg::FRAME_W_RST;
      frame_h   <= btat_pkg::FRAME_H_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        btat_pkg::REG_AREA_TOL:  area_tol  <= cfg_data[btat_pkg::PCT_W-1:0];
        btat_pkg::REG_SHAPE_TOL: shape_tol <= cfg_data;
        btat_pkg::REG_FRAME_W:   frame_w   <= cfg_data;
        btat_pkg::REG_FRAME_H:   frame_h   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid   <= '0;
      e_merged  <= '0;
      label_cnt <= '0;
      frame_cnt <= btat_pkg::FRAME_W'(1);
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
        rsp_data  <= res;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.load) begin
        cur        <= req_data;
        idx        <= '0;
        hit        <= '0;
        free_slot  <= '0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
        best       <= btat_pkg::RADIUS_CAP;
        vis        <= '0;
      end
      if (cmd.scan) begin
        idx <= idx + 1'b1;
        if (e_valid[rd]) begin
          if ((span < btat_pkg::DIST_W'(radius)) && (span < btat_pkg::DIST_W'(best))) begin
            best      <= span[btat_pkg::RAD_W-1:0];
            hit       <= idx;
            hit_found <= 1'b1;
          end
        end else if (!free_found) begin
          free_slot  <= idx;
          free_found <= 1'b1;
        end
      end
      if (cmd.chk1) begin
        prod_wh <= e_w[rd] * e_h[rd];
        dshape  <= btat_pkg::DIST_W'(btat_pkg::absdiff(e_w[rd], cur.box_width))
                 + btat_pkg::DIST_W'(btat_pkg::absdiff(e_h[rd], cur.box_height));
        darea   <= (e_area[rd] > cur.blob_area) ? (e_area[rd] - cur.blob_area)
                                                : (cur.blob_area - e_area[rd]);
      end
      if (cmd.chk2) begin
        area_lim <= btat_pkg::TOL_W'(prod_wh) * btat_pkg::TOL_W'(area_tol);
        darea_x  <= (btat_pkg::TOL_W'(darea) + 1'b1) * btat_pkg::TOL_W'(btat_pkg::PCT_DIV);
      end
      if (cmd.decide) begin
        pass <= hit_found && (dshape < shape_tol) && (darea_x <= area_lim);
      end
      if (cmd.commit) begin
        if (pass) begin
          e_kx[hit] <= cur.corner_x;
          e_ky[hit] <= cur.corner_y;
          if (e_merged[hit]) begin
            e_cx[hit]   <= sum_cx[btat_pkg::COORD_W:1];
            e_cy[hit]   <= sum_cy[btat_pkg::COORD_W:1];
            e_w[hit]    <= sum_w[btat_pkg::COORD_W:1];
            e_h[hit]    <= sum_h[btat_pkg::COORD_W:1];
            e_area[hit] <= sum_area[btat_pkg::AREA_W] ? btat_pkg::AREA_MAX
                                                      : sum_area[btat_pkg::AREA_W-1:0];
          end else begin
            e_cx[hit]     <= cur.center_x;
            e_cy[hit]     <= cur.center_y;
            e_w[hit]      <= cur.box_width;
            e_h[hit]      <= cur.box_height;
            e_area[hit]   <= cur.blob_area;
            if (e_sight[hit] != btat_pkg::SIGHT_MAX) e_sight[hit] <= e_sight[hit] + 1'b1;
            e_last[hit]   <= frame_cnt;
            e_merged[hit] <= 1'b1;
          end
          res <= '{matched: 1'b1, slot: hit, dropped: 1'b0,
                   object_label: e_label[rd], visible_count: '0};
        end else begin
          label_cnt <= label_new;
          if (free_found) begin
            e_valid[free_slot]  <= 1'b1;
            e_merged[free_slot] <= 1'b0;
            e_kx[free_slot]     <= cur.corner_x;
            e_ky[free_slot]     <= cur.corner_y;
            e_cx[free_slot]     <= cur.center_x;
            e_cy[free_slot]     <= cur.center_y;
            e_w[free_slot]      <= cur.box_width;
            e_h[free_slot]      <= cur.box_height;
            e_area[free_slot]   <= cur.blob_area;
            e_sight[free_slot]  <= btat_pkg::SIGHT_W'(1);
            e_last[free_slot]   <= frame_cnt;
            e_label[free_slot]  <= label_new;
            res <= '{matched: 1'b0, slot: free_slot, dropped: 1'b0,
                     object_label: label_new, visible_count: '0};
          end else begin
            res <= '{matched: 1'b0, slot: '0, dropped: 1'b1,
                     object_label: '0, visible_count: '0};
          end
        end
      end
      if (cmd.age) begin
        idx          <= idx + 1'b1;
        e_merged[rd] <= 1'b0;
        if (e_valid[rd] && !seen_now) begin
          if (kill) e_valid[rd] <= 1'b0;
          if ({1'b0, e_cx[rd]} > fw - btat_pkg::FRAME_MIN) begin
            e_cx[rd] <= fw[btat_pkg::COORD_W-1:0] - 1'b1;
          end
          if ({1'b0, e_cy[rd]} > fh - btat_pkg::FRAME_MIN) begin
            e_cy[rd] <= fh[btat_pkg::COORD_W-1:0] - 1'b1;
          end
        end
        if (e_valid[rd] && seen_now && (e_sight[rd] > btat_pkg::YOUNG_SIGHTINGS)) begin
          vis <= vis + 1'b1;
        end
      end
      if (cmd.frame) begin
        frame_cnt <= frame_cnt + 1'b1;
        res <= '{matched: 1'b0, slot: '0, dropped: 1'b0,
                 object_label: '0, visible_count: vis};
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/btat_checker.sv =====
// Port checker of the track association table and its bind.
`default_nettype none
`include "blob_track_association_table_top_defines.svh"
module btat_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire btat_pkg::rsp_t rsp_data
);

  `BTAT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "accepted twice")
  `BTAT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp dropped")
  `BTAT_ASSERT_NOW(a_drop_word, rsp_valid && rsp_data.dropped, !rsp_data.matched && rsp_data.slot == '0 && rsp_data.object_label == '0, "bad drop word")
  `BTAT_ASSERT_NOW(a_frame_word, rsp_valid && rsp_data.visible_count != '0, !rsp_data.matched && !rsp_data.dropped && rsp_data.object_label == '0, "bad frame word")

endmodule

bind blob_track_association_table_top btat_checker u_btat_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
`default_nettype wire

// ===== tb/sv/tb_chan_if.sv =====
// Word types used by the bench.
`default_nettype none
package tb_btat_pkg;
  typedef struct {
    bit                             is_cfg;
    logic [btat_pkg::CFG_IDX_W-1:0] idx;
    logic [btat_pkg::CFG_W-1:0]     val;
    btat_pkg::req_t                 word;
  } stim_t;
endpackage
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking bench of the track association table: predictor, driver and monitor.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  btat_in_if  req();
  btat_out_if rsp();
  btat_cfg_if cfg();

  blob_track_association_table_top dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  initial forever #5 clk = ~clk;

  // predictor state
  logic [btat_pkg::PCT_W-1:0]   p_area_tol;
  logic [btat_pkg::CFG_W-1:0]   p_shape_tol, p_fw, p_fh;
  bit                           t_valid [btat_pkg::ENTRIES];
  bit                           t_merged[btat_pkg::ENTRIES];
  logic [btat_pkg::COORD_W-1:0] t_cx[btat_pkg::ENTRIES], t_cy[btat_pkg::ENTRIES];
  logic [btat_pkg::COORD_W-1:0] t_kx[btat_pkg::ENTRIES], t_ky[btat_pkg::ENTRIES];
  logic [btat_pkg::COORD_W-1:0] t_w[btat_pkg::ENTRIES], t_h[btat_pkg::ENTRIES];
  logic [btat_pkg::AREA_W-1:0]  t_area[btat_pkg::ENTRIES];
  logic [btat_pkg::SIGHT_W-1:0] t_sight[btat_pkg::ENTRIES];
  logic [btat_pkg::FRAME_W-1:0] t_last[btat_pkg::ENTRIES];
  logic [btat_pkg::LABEL_W-1:0] t_label[btat_pkg::ENTRIES];
  logic [btat_pkg::LABEL_W-1:0] label_ctr;
  logic [btat_pkg::FRAME_W-1:0] frame_ctr;

  tb_btat_pkg::stim_t pending[$];
  btat_pkg::rsp_t     expected_rsp[$];
  int    errors = 0;
  int    in_idle_pct = 37, out_idle_pct = 68;
  bit    req_taken, cfg_taken;

  function automatic logic [btat_pkg::COORD_W-1:0] dif(logic [btat_pkg::COORD_W-1:0] a,
                                                       logic [btat_pkg::COORD_W-1:0] b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic void tracker_reset();
    p_area_tol = btat_pkg::AREA_TOL_RST; p_shape_tol = btat_pkg::SHAPE_TOL_RST;
    p_fw = btat_pkg::FRAME_W_RST; p_fh = btat_pkg::FRAME_H_RST;
    for (int i = 0; i < btat_pkg::ENTRIES; i++) begin
      t_valid[i] = 1'b0; t_merged[i] = 1'b0;
    end
    label_ctr = '0; frame_ctr = btat_pkg::FRAME_W'(1);
  endfunction

  function automatic void tracker_config(logic [btat_pkg::CFG_IDX_W-1:0] idx,
                                         logic [btat_pkg::CFG_W-1:0] v);
    case (idx)
      btat_pkg::REG_AREA_TOL:  p_area_tol = v[btat_pkg::PCT_W-1:0];
      btat_pkg::REG_SHAPE_TOL: p_shape_tol = v;
      btat_pkg::REG_FRAME_W:   p_fw = v;
      btat_pkg::REG_FRAME_H:   p_fh = v;
      default: ;
    endcase
  endfunction

  function automatic btat_pkg::rsp_t track_word(btat_pkg::req_t r);
    btat_pkg::rsp_t o;
    logic [btat_pkg::CFG_W-1:0] fw, fh;
    logic [btat_pkg::FRAME_W-1:0] age;
    logic [13:0] span, best;
    logic [7:0] radius;
    logic [63:0] maxvar;
    logic [13:0] dshape;
    logic [24:0] sum;
    int hit, fr;
    o = '0;
    if (r.req_type) begin
      fw = p_fw < 2 ? 13'd2 : p_fw;
      fh = p_fh < 2 ? 13'd2 : p_fh;
      for (int i = 0; i < btat_pkg::ENTRIES; i++) begin
        if (t_valid[i] && t_last[i] != frame_ctr) begin
          age = frame_ctr - t_last[i];
          if (t_sight[i] < 5) begin
            if (age > 5) t_valid[i] = 1'b0;
          end else if (age > 50) t_valid[i] = 1'b0;
          if (t_cx[i] > fw - 2) t_cx[i] = btat_pkg::COORD_W'(fw - 1);
          if (t_cy[i] > fh - 2) t_cy[i] = btat_pkg::COORD_W'(fh - 1);
        end
        t_merged[i] = 1'b0;
      end
      for (int i = 0; i < btat_pkg::ENTRIES; i++)
        if (t_valid[i] && t_sight[i] > 5 && t_last[i] == frame_ctr) o.visible_count++;
      frame_ctr++;
      return o;
    end
    best = 14'd101; hit = -1;
    for (int i = 0; i < btat_pkg::ENTRIES; i++) begin
      if (!t_valid[i]) continue;
      age = frame_ctr - t_last[i];
      radius = age >= 73 ? 8'd101 : 8'(28 + age);
      span = dif(t_cx[i], r.center_x) + dif(t_cy[i], r.center_y);
      if (span < radius && span < best) begin
        best = span; hit = i;
      end
    end
    if (hit >= 0) begin
      maxvar = (64'(t_w[hit]) * t_h[hit] * p_area_tol) / 100;
      dshape = dif(t_w[hit], r.box_width) + dif(t_h[hit], r.box_height);
      if (!(dshape < p_shape_tol &&
            64'(t_area[hit] > r.blob_area ? t_area[hit] - r.blob_area
                                          : r.blob_area - t_area[hit]) < maxvar))
        hit = -1;
    end
    if (hit >= 0) begin
      t_kx[hit] = r.corner_x; t_ky[hit] = r.corner_y;
      if (t_merged[hit]) begin
        sum = t_area[hit] + r.blob_area;
        t_cx[hit] = btat_pkg::COORD_W'((13'(t_cx[hit]) + r.center_x) >> 1);
        t_cy[hit] = btat_pkg::COORD_W'((13'(t_cy[hit]) + r.center_y) >> 1);
        t_area[hit] = sum > btat_pkg::AREA_MAX ? btat_pkg::AREA_MAX
                                               : sum[btat_pkg::AREA_W-1:0];
        t_w[hit] = btat_pkg::COORD_W'((13'(t_w[hit]) + r.box_width) >> 1);
        t_h[hit] = btat_pkg::COORD_W'((13'(t_h[hit]) + r.box_height) >> 1);
      end else begin
        t_cx[hit] = r.center_x; t_cy[hit] = r.center_y; t_area[hit] = r.blob_area;
        t_w[hit] = r.box_width; t_h[hit] = r.box_height;
        if (t_sight[hit] < 255) t_sight[hit]++;
        t_last[hit] = frame_ctr; t_merged[hit] = 1'b1;
      end
      o.matched = 1'b1; o.slot = btat_pkg::IDX_W'(hit); o.object_label = t_label[hit];
      return o;
    end
    label_ctr++;
    fr = -1;
    for (int i = 0; i < btat_pkg::ENTRIES; i++)
      if (!t_valid[i]) begin
        fr = i; break;
      end
    if (fr < 0) begin
      o.dropped = 1'b1;
      return o;
    end
    t_valid[fr] = 1'b1; t_kx[fr] = r.corner_x; t_ky[fr] = r.corner_y;
    t_cx[fr] = r.center_x; t_cy[fr] = r.center_y; t_area[fr] = r.blob_area;
    t_w[fr] = r.box_width; t_h[fr] = r.box_height; t_sight[fr] = btat_pkg::SIGHT_W'(1);
    t_last[fr] = frame_ctr; t_merged[fr] = 1'b0; t_label[fr] = label_ctr;
    o.slot = btat_pkg::IDX_W'(fr); o.object_label = label_ctr;
    return o;
  endfunction

  function automatic btat_pkg::req_t blob_word(int x, int y, int w, int h, int a);
    btat_pkg::req_t r;
    r.req_type = 1'b0;
    r.center_x = btat_pkg::COORD_W'(x); r.center_y = btat_pkg::COORD_W'(y);
    r.corner_x = btat_pkg::COORD_W'($urandom); r.corner_y = btat_pkg::COORD_W'($urandom);
    r.box_width = btat_pkg::COORD_W'(w); r.box_height = btat_pkg::COORD_W'(h);
    r.blob_area = btat_pkg::AREA_W'(a);
    return r;
  endfunction

  function automatic void push_word(btat_pkg::req_t r);
    tb_btat_pkg::stim_t s;
    s.is_cfg = 1'b0; s.word = r; s.idx = '0; s.val = '0;
    pending = {pending, s};
  endfunction

  function automatic void push_cfg(logic [btat_pkg::CFG_IDX_W-1:0] i,
                                   logic [btat_pkg::CFG_W-1:0] v);
    tb_btat_pkg::stim_t s;
    s.is_cfg = 1'b1; s.idx = i; s.val = v; s.word = '0;
    pending = {pending, s};
  endfunction

  function automatic void push_frame_end();
    btat_pkg::req_t r;
    r = '0; r.req_type = 1'b1;
    r.center_x = btat_pkg::COORD_W'($urandom); r.blob_area = btat_pkg::AREA_W'($urandom);
    push_word(r);
  endfunction

  // random tracked scene: a few objects that drift, plus noise
  task automatic fill_scene(int nitems);
    int ox[8], oy[8], ow[8], oh[8];
    int n;
    n = 0;
    for (int k = 0; k < 8; k++) begin
      ox[k] = $urandom_range(4095); oy[k] = $urandom_range(4095);
      ow[k] = $urandom_range(60, 1); oh[k] = $urandom_range(60, 1);
    end
    while (n < nitems) begin
      case ($urandom_range(9))
        0: push_frame_end();
        1: push_word(blob_word($urandom, $urandom, $urandom, $urandom, $urandom));
        default: begin
          int k = $urandom_range(7);
          ox[k] = (ox[k] + $urandom_range(20) - 10) & 12'hFFF;
          oy[k] = (oy[k] + $urandom_range(20) - 10) & 12'hFFF;
          push_word(blob_word(ox[k], oy[k], ow[k] + $urandom_range(3), oh[k] + $urandom_range(3),
                              ow[k] * oh[k] + $urandom_range(40)));
          if ($urandom_range(3) == 0) push_frame_end();
        end
      endcase
      n++;
    end
  endtask

  // accept capture
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0; cfg_taken <= 1'b0;
    end else begin
      req_taken <= req.valid && req.ready;
      cfg_taken <= cfg.valid && cfg.ready;
    end
  end

  // driver
  always @(negedge clk) begin : drive
    tb_btat_pkg::stim_t s;
    logic nv_req, nv_cfg;
    if (rst) begin
      req.valid <= 1'b0; cfg.valid <= 1'b0;
    end else begin
      if (req_taken) expected_rsp = {expected_rsp, track_word(req.data)};
      if (cfg_taken) tracker_config(cfg.index, cfg.data);
      if (!(req.valid && !req_taken) && !(cfg.valid && !cfg_taken)) begin
        nv_req = 1'b0; nv_cfg = 1'b0;
        if (pending.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          s = pending.pop_front();
          if (s.is_cfg) begin
            nv_cfg = 1'b1; cfg.index <= s.idx; cfg.data <= s.val;
          end else begin
            nv_req = 1'b1; req.data <= s.word;
          end
        end
        req.valid <= nv_req; cfg.valid <= nv_cfg;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    btat_pkg::rsp_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t unexpected result %p", $realtime, rsp.data);
        errors++;
      end else begin
        e = expected_rsp.pop_front();
        if (rsp.data.matched !== e.matched || rsp.data.slot !== e.slot ||
            rsp.data.dropped !== e.dropped || rsp.data.object_label !== e.object_label ||
            rsp.data.visible_count !== e.visible_count) begin
          $display("%0t mismatch expected %p actual %p", $realtime, e, rsp.data);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) rsp.ready <= rst ? 1'b0 : ($urandom_range(99) >= out_idle_pct);

  // quiesce: wait for the bench queue, channel and results to drain
  task automatic drain();
    while (pending.size() > 0 || req.valid || cfg.valid || expected_rsp.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_all(int a, int s, int w, int h);
    push_cfg(btat_pkg::REG_AREA_TOL, btat_pkg::CFG_W'(a));
    push_cfg(btat_pkg::REG_SHAPE_TOL, btat_pkg::CFG_W'(s));
    push_cfg(btat_pkg::REG_FRAME_W, btat_pkg::CFG_W'(w));
    push_cfg(btat_pkg::REG_FRAME_H, btat_pkg::CFG_W'(h));
  endtask

  initial begin
    req.valid = 1'b0; req.data = '0; cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    rsp.ready = 1'b0;
    tracker_reset();
    repeat (11) @(posedge clk);
    @(negedge clk) rst = 0;

    // directed: create, refresh, merge, size fail, extremes, full table, ageing
    push_word(blob_word(100, 100, 10, 10, 100));
    push_word(blob_word(105, 100, 10, 10, 101));
    push_word(blob_word(103, 102, 12, 9, 100));
    push_word(blob_word(100, 100, 300, 300, 100));
    push_word(blob_word(0, 0, 0, 0, 0));
    push_word(blob_word(4095, 4095, 4095, 4095, 24'hFFFFFF));
    push_frame_end();
    for (int i = 0; i < 14; i++) push_word(blob_word(300 * i + 200, 2000, 5, 5, 25));
    push_word(blob_word(4000, 10, 5, 5, 25));
    for (int i = 0; i < 7; i++) push_frame_end();
    drain();
    set_all(100, 8191, 2, 2);
    drain();
    push_word(blob_word(4095, 4095, 4095, 4095, 24'hFFFFFF));
    push_word(blob_word(4095, 4095, 4095, 4095, 24'hFFFFF0));
    push_frame_end(); push_frame_end();
    fill_scene(120);
    drain();
    set_all(0, 0, 4096, 4096);
    drain();
    fill_scene(80);
    drain();
    set_all(20, 100, 640, 480);
    drain();
    fill_scene(170);
    drain();
    in_idle_pct = 68; out_idle_pct = 37;
    set_all($urandom_range(100), $urandom_range(8191), $urandom_range(4096, 2),
            $urandom_range(4096, 2));
    drain();
    fill_scene(210);
    drain();
    in_idle_pct = 0; out_idle_pct = 0;
    set_all(50, 200, 1000, 700);
    drain();
    fill_scene(210);
    drain();
    if (errors == 0 && expected_rsp.size() == 0) $display("PASS blob_track_association_table_top");
    else $display("FAIL blob_track_association_table_top");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL blob_track_association_table_top");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/btat_pkg.sv
hw/rtl/btat_in_if.sv
hw/rtl/btat_out_if.sv
hw/rtl/btat_cfg_if.sv
hw/rtl/btat_ctrl.sv
hw/rtl/btat_datapath.sv
hw/rtl/blob_track_association_table_top.sv
hw/rtl/btat_checker.sv
tb/sv/tb_chan_if.sv
tb/sv/tb.sv
